/* src/htjg_pkg.sv */
// Shared types, constants and state encoding for the Halton jitter generator.
`default_nettype none
package htjg_pkg;

  // Default sample count; the modulus is a parameter of the top level.
  localparam int DEF_SAMPLE_COUNT = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 1'b1;

  localparam int VIEWPORT_W = 15;
  localparam logic [VIEWPORT_W-1:0] WIDTH_RESET  = 15'd1920;
  localparam logic [VIEWPORT_W-1:0] HEIGHT_RESET = 15'd1080;

  // Data widths, sized for the largest supported sample count of 256.
  localparam int INDEX_W = 32;
  localparam int FRAC_W  = 32;
  localparam int MREM_W  = 8;   // remainder below the largest sample count
  localparam int MSUM_W  = 9;   // sum of two remainders before the final subtraction
  localparam int K_W     = 9;   // k runs from 1 to 256
  localparam int NUM_W   = 11;  // base-3 numerator, doubled during long division
  localparam int DEN_W   = 10;  // 3^6 = 729 at most
  localparam int DREM_W  = VIEWPORT_W + 1;

  // Reciprocal of three for a 9-bit value: q = (k * 171) >> 9.
  localparam int RECIP3       = 171;
  localparam int RECIP3_SHIFT = 9;
  localparam int PROD3_W      = K_W + 8;

  // Iterative phases: bits retired per cycle and resulting cycle counts.
  localparam int MOD_BITS    = 8;
  localparam int MOD_CYCLES  = INDEX_W / MOD_BITS;
  localparam int FRAC_BITS   = 4;
  localparam int FRAC_CYCLES = FRAC_W / FRAC_BITS;
  localparam int DIV_BITS    = 2;
  localparam int DIV_CYCLES  = FRAC_W / DIV_BITS;
  localparam int CNT_W       = $clog2(DIV_CYCLES);

  // Constant remainder table, one entry for each value of an index byte.
  typedef logic [(1 << MOD_BITS)-1:0][MREM_W-1:0] mod_tab_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_KLOAD,
    S_DIGIT,
    S_FRAC,
    S_PREP,
    S_DIV,
    S_DONE
  } htjg_state_t;

  typedef struct packed {
    logic mod_load;
    logic mod_step;
    logic k_load;
    logic digit_step;
    logic frac_step;
    logic div_prep;
    logic div_step;
    logic out_load;
  } htjg_cmd_t;

  typedef struct packed {
    logic k_last;
  } htjg_status_t;

endpackage
`default_nettype wire

/* src/htjg_datapath.sv */
// Datapath: modulo reduction, radical inverses, signed division and result registers.
`default_nettype none
module htjg_datapath import htjg_pkg::*; #(
  parameter int SAMPLE_COUNT = DEF_SAMPLE_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [VIEWPORT_W-1:0] cfg_data,
  input  wire logic [INDEX_W-1:0]    frame_index,
  input  wire htjg_cmd_t             cmd,
  output htjg_status_t               status,
  output logic signed [FRAC_W-1:0]   jitter_x,
  output logic signed [FRAC_W-1:0]   jitter_y,
  output logic signed [FRAC_W-1:0]   prev_jitter_x,
  output logic signed [FRAC_W-1:0]   prev_jitter_y
);

  localparam int MODULUS = (SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT;
  localparam logic [MSUM_W-1:0] MOD_C = MSUM_W'(MODULUS);
  localparam logic [FRAC_W-1:0] HALF  = {1'b1, {(FRAC_W-1){1'b0}}};

  function automatic mod_tab_t mod_table(input int scale);
    mod_tab_t t;
    for (int i = 0; i < (1 << MOD_BITS); i++) begin
      t[i] = MREM_W'((i * scale) % MODULUS);
    end
    return t;
  endfunction

  // Remainder of a value moved up one byte, and remainder of a byte on its own.
  localparam mod_tab_t SHIFT_TAB = mod_table(1 << MOD_BITS);
  localparam mod_tab_t BYTE_TAB  = mod_table(1);

  logic [VIEWPORT_W-1:0] viewport_width, viewport_height;
  logic [INDEX_W-1:0]    idx_sh,  idx_sh_next;
  logic [MREM_W-1:0]     mrem,    mrem_next;
  logic [MSUM_W-1:0]     mod_sum;
  logic [K_W-1:0]        kr,      kr_next;
  logic [NUM_W-1:0]      num,     num_next;
  logic [DEN_W-1:0]      den,     den_next;
  logic [FRAC_W-1:0]     frac2,   frac2_next;
  logic [FRAC_W-1:0]     fq,      fq_next;
  logic [FRAC_W-1:0]     qx,      qx_next, qy, qy_next;
  logic [DREM_W-1:0]     rx,      rx_next, ry, ry_next;
  logic [VIEWPORT_W-1:0] dx,      dy;
  logic                  sx,      sy;
  logic [FRAC_W-1:0]     last_x,  last_y;

  logic [K_W-1:0]        k_init;
  logic [PROD3_W-1:0]    prod3;
  logic [K_W-1:0]        q3, t3;
  logic [1:0]            r3;
  logic [FRAC_W-1:0]     res_x, res_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width  <= WIDTH_RESET;
      viewport_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VIEWPORT_WIDTH:  viewport_width  <= cfg_data;
        REG_VIEWPORT_HEIGHT: viewport_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame index modulo the sample count, one byte a cycle from the top. Both table
  // entries are below the modulus, so a single subtraction completes each step.
  always_comb begin
    mod_sum     = MSUM_W'(SHIFT_TAB[mrem]) +
                  MSUM_W'(BYTE_TAB[idx_sh[INDEX_W-1 -: MOD_BITS]]);
    mrem_next   = (mod_sum >= MOD_C) ? MREM_W'(mod_sum - MOD_C) : MREM_W'(mod_sum);
    idx_sh_next = {idx_sh[INDEX_W-MOD_BITS-1:0], MOD_BITS'(0)};
  end

  // One base-3 digit a cycle, the division by three done by reciprocal.
  always_comb begin
    k_init = K_W'(mrem) + K_W'(1);
    prod3  = PROD3_W'(kr) * PROD3_W'(RECIP3);
    q3     = K_W'(prod3 >> RECIP3_SHIFT);
    t3     = K_W'({q3, 1'b0}) + q3;
    r3     = 2'(kr - t3);
    kr_next  = q3;
    num_next = NUM_W'({num, 1'b0}) + num + NUM_W'(r3);
    den_next = DEN_W'({den, 1'b0}) + den;
    status.k_last = (q3 == '0);
  end

  // Bit reversal of k is the base-2 radical inverse.
  always_comb begin
    frac2_next = '0;
    for (int i = 0; i < K_W; i++) begin
      frac2_next[FRAC_W-1-i] = k_init[i];
    end
  end

  // Fraction num/den by restoring long division.
  logic [NUM_W-1:0] num_frac;
  always_comb begin
    num_frac = num;
    fq_next  = fq;
    for (int i = 0; i < FRAC_BITS; i++) begin
      num_frac = {num_frac[NUM_W-2:0], 1'b0};
      fq_next  = {fq_next[FRAC_W-2:0], 1'b0};
      if (num_frac >= NUM_W'(den)) begin
        num_frac   = num_frac - NUM_W'(den);
        fq_next[0] = 1'b1;
      end
    end
  end

  // Two lanes of restoring division of the magnitude by the viewport size.
  always_comb begin
    rx_next = rx;
    qx_next = qx;
    ry_next = ry;
    qy_next = qy;
    for (int i = 0; i < DIV_BITS; i++) begin
      rx_next = {rx_next[DREM_W-2:0], qx_next[FRAC_W-1]};
      qx_next = {qx_next[FRAC_W-2:0], 1'b0};
      if (rx_next >= DREM_W'(dx)) begin
        rx_next    = rx_next - DREM_W'(dx);
        qx_next[0] = 1'b1;
      end
      ry_next = {ry_next[DREM_W-2:0], qy_next[FRAC_W-1]};
      qy_next = {qy_next[FRAC_W-2:0], 1'b0};
      if (ry_next >= DREM_W'(dy)) begin
        ry_next    = ry_next - DREM_W'(dy);
        qy_next[0] = 1'b1;
      end
    end
  end

  assign res_x = sx ? (~qx + FRAC_W'(1)) : qx;
  assign res_y = sy ? (~qy + FRAC_W'(1)) : qy;

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      idx_sh <= frame_index;
      mrem   <= '0;
    end else if (cmd.mod_step) begin
      idx_sh <= idx_sh_next;
      mrem   <= mrem_next;
    end
    if (cmd.k_load) begin
      kr    <= k_init;
      num   <= '0;
      den   <= DEN_W'(1);
      frac2 <= frac2_next;
    end else if (cmd.digit_step) begin
      kr  <= kr_next;
      num <= num_next;
      den <= den_next;
    end else if (cmd.frac_step) begin
      num <= num_frac;
      fq  <= fq_next;
    end
    if (cmd.div_prep) begin
      // Centre on one half: a fraction below one half gives a negative jitter.
      sx <= ~frac2[FRAC_W-1];
      qx <= frac2[FRAC_W-1] ? (frac2 ^ HALF) : (HALF - frac2);
      sy <= ~fq[FRAC_W-1];
      qy <= fq[FRAC_W-1] ? (fq ^ HALF) : (HALF - fq);
      rx <= '0;
      ry <= '0;
      dx <= (viewport_width == '0) ? VIEWPORT_W'(1) : viewport_width;
      dy <= (viewport_height == '0) ? VIEWPORT_W'(1) : viewport_height;
    end else if (cmd.div_step) begin
      qx <= qx_next;
      rx <= rx_next;
      qy <= qy_next;
      ry <= ry_next;
    end
    if (cmd.out_load) begin
      jitter_x      <= res_x;
      jitter_y      <= res_y;
      prev_jitter_x <= last_x;
      prev_jitter_y <= last_y;
    end
  end

  // Jitter of the previous frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (cmd.out_load) begin
      last_x <= res_x;
      last_y <= res_y;
    end
  end

endmodule
`default_nettype wire

/* src/htjg_ctrl.sv */
// Controller: phase sequencing, step counter and the output handshake.
`default_nettype none
module htjg_ctrl import htjg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire htjg_status_t status,
  output htjg_cmd_t         cmd
);

  htjg_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;
  logic             out_free;
  logic             out_valid_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_MOD;
      S_MOD:   if (cnt == CNT_W'(MOD_CYCLES - 1)) state_next = S_KLOAD;
      S_KLOAD: state_next = S_DIGIT;
      S_DIGIT: if (status.k_last) state_next = S_FRAC;
      S_FRAC:  if (cnt == CNT_W'(FRAC_CYCLES - 1)) state_next = S_PREP;
      S_PREP:  state_next = S_DIV;
      S_DIV:   if (cnt == CNT_W'(DIV_CYCLES - 1)) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.mod_load   = accept;
    cmd.mod_step   = (state == S_MOD);
    cmd.k_load     = (state == S_KLOAD);
    cmd.digit_step = (state == S_DIGIT);
    cmd.frac_step  = (state == S_FRAC);
    cmd.div_prep   = (state == S_PREP);
    cmd.div_step   = (state == S_DIV);
    cmd.out_load   = (state == S_DONE) && out_free;
    cnt_next       = (state_next != state) ? '0 : cnt + CNT_W'(1);
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a beat was still waiting");

  // Loading the result register always presents a beat next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // The division phase runs for exactly its step count.
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |=> ##(DIV_CYCLES) (state == S_DONE))
    else $error("division phase length wrong");

  // An accepted beat starts the modulo phase with a cleared counter.
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MOD) && (cnt == '0))
    else $error("accepted beat did not start the modulo phase");

endmodule
`default_nettype wire

/* src/halton_taa_jitter_generator.sv */
// A frame index beat passes through the modulo, base-3 digit, fraction long division
// and viewport division phases of one datapath, then out_valid rises.
// The digit phase steps once per base-3 digit of k (1 to 3 at the default sample count,
// at most 6). No new index is taken until the previous result is loaded.
// A new index is taken while the previous result still waits to be read.
// Reset: viewport registers return to 1920 x 1080 and the stored previous jitter to zero.
`default_nettype none
module halton_taa_jitter_generator import htjg_pkg::*; #(
  parameter int SAMPLE_COUNT = DEF_SAMPLE_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [VIEWPORT_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [INDEX_W-1:0]    frame_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [FRAC_W-1:0]   jitter_x,
  output logic signed [FRAC_W-1:0]   jitter_y,
  output logic signed [FRAC_W-1:0]   prev_jitter_x,
  output logic signed [FRAC_W-1:0]   prev_jitter_y
);

  htjg_cmd_t    cmd;
  htjg_status_t status;

  htjg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  htjg_datapath #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_index   (frame_index),
    .cmd           (cmd),
    .status        (status),
    .jitter_x      (jitter_x),
    .jitter_y      (jitter_y),
    .prev_jitter_x (prev_jitter_x),
    .prev_jitter_y (prev_jitter_y)
  );

endmodule
`default_nettype wire
